### hdl/tlblru_pkg.sv
// ----------------------------------------------------------------------------
// tlblru_pkg: shared types and constants for the translation buffer
// Field widths, command codes, score limits and the control/status bundles
// that pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package tlblru_pkg;

	// item field widths
	localparam int CMD_W   = 2;
	localparam int VA_W    = 24;
	localparam int PA_W    = 24;
	localparam int OFF_W   = 8;
	localparam int PAGE_W  = VA_W - OFF_W;
	localparam int TIDX_W  = 14;
	localparam int TWORD_W = 24;
	localparam int SLOT_W  = 3;

	// scores run from -1 (empty entry) up to a saturating ceiling
	localparam int SCORE_W = 29;
	localparam logic signed [SCORE_W-1:0] SCORE_MAX  = 29'sh0FFFFFFF;
	localparam logic signed [SCORE_W-1:0] SCORE_NONE = -29'sd1;

	// register port
	localparam int APB_DATA_W = 32;
	localparam int PADDR_W    = 3;
	localparam int REG_IDX_W  = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_TABLE_BASE = 1'b0;

	// item commands; the fourth code is a no-op
	typedef enum logic [CMD_W-1:0] {
		CMD_XLATE    = 2'd0,
		CMD_PT_WRITE = 2'd1,
		CMD_FLUSH    = 2'd2
	} cmd_t;

	// sequencer -> datapath
	typedef struct packed {
		logic capture;      // latch the incoming item and its lookup
		logic miss_start;   // read the page table, seed the victim choice
		logic scan_step;    // compare one more entry score
		logic commit;       // finish a hit, table write, flush or no-op
		logic fill_commit;  // refill the victim and emit the miss result
	} dp_cmd_t;

	// datapath -> sequencer
	typedef struct packed {
		logic xlate;
		logic hit;
		logic free_avail;
		logic scan_last;
		logic out_free;
	} dp_stat_t;

endpackage

### hdl/tlblru_ifs.sv
// ----------------------------------------------------------------------------
// tlblru request / response channels
// Valid/ready channels carrying one item beat and one result beat.
// ----------------------------------------------------------------------------
interface tlblru_req_if;
	logic                               valid;
	logic                               ready;
	logic [tlblru_pkg::CMD_W-1:0]       cmd;
	logic [tlblru_pkg::VA_W-1:0]        virt_addr;
	logic [tlblru_pkg::TIDX_W-1:0]      table_index;
	logic [tlblru_pkg::TWORD_W-1:0]     table_word;

	modport source (output valid, cmd, virt_addr, table_index, table_word, input ready);
	modport sink   (input valid, cmd, virt_addr, table_index, table_word, output ready);
endinterface

interface tlblru_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [tlblru_pkg::PA_W-1:0]        phys_addr;
	logic                               hit;
	logic [tlblru_pkg::SLOT_W-1:0]      slot;

	modport source (output valid, phys_addr, hit, slot, input ready);
	modport sink   (input valid, phys_addr, hit, slot, output ready);
endinterface

### hdl/tlblru_dp.sv
// ----------------------------------------------------------------------------
// tlblru_dp: translation buffer datapath
// Entry array with parallel page compare, running top score, victim scan,
// page-table memory and the result register.
// ----------------------------------------------------------------------------
module tlblru_dp #(
	parameter int TLB_ENTRIES   = 8,
	parameter int TABLE_ENTRIES = 16384
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tlblru_pkg::dp_cmd_t               ctl,
	output tlblru_pkg::dp_stat_t              stat,
	// item payload
	input  logic [tlblru_pkg::CMD_W-1:0]      in_cmd,
	input  logic [tlblru_pkg::VA_W-1:0]       in_va,
	input  logic [tlblru_pkg::TIDX_W-1:0]     in_tidx,
	input  logic [tlblru_pkg::TWORD_W-1:0]    in_tword,
	// result channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [tlblru_pkg::PA_W-1:0]       out_phys,
	output logic                              out_hit,
	output logic [tlblru_pkg::SLOT_W-1:0]     out_slot,
	// table base register
	input  logic                              cfg_we,
	input  logic [tlblru_pkg::TIDX_W-1:0]     cfg_wdata,
	output logic [tlblru_pkg::TIDX_W-1:0]     table_base
);

	localparam int IDX_W = $clog2(TLB_ENTRIES);
	localparam int AW    = $clog2(TABLE_ENTRIES);
	// table_base + page needs one bit more than the page
	localparam int SUM_W = tlblru_pkg::PAGE_W + 1;
	// quotient bits of the widest sum over the table size
	localparam int QB    = $clog2(((1 << SUM_W) - 1) / TABLE_ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TLB_ENTRIES - 1);

	// table index reduction: restoring compare-subtract, one quotient bit a step
	function automatic logic [AW-1:0] tbl_mod_f(input logic [SUM_W-1:0] x);
		logic [SUM_W+QB-1:0] r;
		logic [SUM_W+QB-1:0] d;
		r = (SUM_W+QB)'(x);
		for (int k = QB - 1; k >= 0; k--) begin
			d = (SUM_W+QB)'(TABLE_ENTRIES) << k;
			if (r >= d) begin
				r = r - d;
			end
		end
		return AW'(r);
	endfunction

	// entry storage
	logic [TLB_ENTRIES-1:0]                     valid_q;
	logic [tlblru_pkg::PAGE_W-1:0]              ent_page_q  [TLB_ENTRIES];
	logic [tlblru_pkg::PA_W-1:0]                ent_frame_q [TLB_ENTRIES];
	logic signed [tlblru_pkg::SCORE_W-1:0]      score_q     [TLB_ENTRIES];
	logic signed [tlblru_pkg::SCORE_W-1:0]      top_q;

	// captured item
	logic [tlblru_pkg::CMD_W-1:0]               cmd_q;
	logic [tlblru_pkg::PAGE_W-1:0]              page_q;
	logic [tlblru_pkg::OFF_W-1:0]               off_q;
	logic [tlblru_pkg::TIDX_W-1:0]              tidx_q;
	logic [tlblru_pkg::TWORD_W-1:0]             tword_q;
	logic [SUM_W-1:0]                           sum_q;
	logic                                       hit_q;
	logic [IDX_W-1:0]                           hit_idx_q;
	logic                                       free_q;
	logic [IDX_W-1:0]                           free_idx_q;

	// victim search
	logic signed [tlblru_pkg::SCORE_W-1:0]      low_q;
	logic [IDX_W-1:0]                           vic_q;
	logic [IDX_W-1:0]                           cnt_q;

	// page table
	logic [tlblru_pkg::TWORD_W-1:0]             pt_mem [TABLE_ENTRIES];
	logic [tlblru_pkg::TWORD_W-1:0]             pt_rd_q;

	// result register
	logic                                       out_valid_q;
	logic [tlblru_pkg::PA_W-1:0]                phys_q;
	logic                                       ohit_q;
	logic [tlblru_pkg::SLOT_W-1:0]              slot_q;
	logic [tlblru_pkg::TIDX_W-1:0]              table_base_q;

	logic [TLB_ENTRIES-1:0]                     match;
	logic [IDX_W-1:0]                           match_idx;
	logic [IDX_W-1:0]                           first_free;
	logic signed [tlblru_pkg::SCORE_W-1:0]      next_score;
	logic [SUM_W-1:0]                           mod_in;
	logic [AW-1:0]                              pt_addr;
	logic                                       is_xlate;
	logic                                       out_free;

	// parallel page compare on the incoming address, first match and first hole
	always_comb begin
		match      = '0;
		match_idx  = '0;
		first_free = '0;
		for (int e = 0; e < TLB_ENTRIES; e++) begin
			match[e] = valid_q[e] &&
				(ent_page_q[e] == in_va[tlblru_pkg::VA_W-1:tlblru_pkg::OFF_W]);
		end
		for (int e = TLB_ENTRIES - 1; e >= 0; e--) begin
			if (match[e]) begin
				match_idx = IDX_W'(e);
			end
			if (!valid_q[e]) begin
				first_free = IDX_W'(e);
			end
		end
	end

	// every new score is one above the current top, capped
	assign next_score = (top_q == tlblru_pkg::SCORE_MAX) ? tlblru_pkg::SCORE_MAX
	                                                     : top_q + tlblru_pkg::SCORE_W'(1);

	assign is_xlate = (cmd_q == tlblru_pkg::CMD_XLATE);
	assign out_free = !out_valid_q || out_ready;

	// one reduction unit serves both the table write and the refill read
	assign mod_in  = (cmd_q == tlblru_pkg::CMD_PT_WRITE) ? SUM_W'(tidx_q) : sum_q;
	assign pt_addr = tbl_mod_f(mod_in);

	// item capture
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q      <= in_cmd;
			page_q     <= in_va[tlblru_pkg::VA_W-1:tlblru_pkg::OFF_W];
			off_q      <= in_va[tlblru_pkg::OFF_W-1:0];
			tidx_q     <= in_tidx;
			tword_q    <= in_tword;
			sum_q      <= SUM_W'(table_base_q) +
			              SUM_W'(in_va[tlblru_pkg::VA_W-1:tlblru_pkg::OFF_W]);
			hit_q      <= |match;
			hit_idx_q  <= match_idx;
			free_q     <= ~&valid_q;
			free_idx_q <= first_free;
		end
	end

	// victim choice: first hole, else lowest score scanning one entry a cycle
	always_ff @(posedge clk) begin
		if (ctl.miss_start) begin
			low_q <= score_q[0];
			vic_q <= free_q ? free_idx_q : '0;
			cnt_q <= IDX_W'(1);
		end else if (ctl.scan_step) begin
			if (score_q[cnt_q] < low_q) begin
				low_q <= score_q[cnt_q];
				vic_q <= cnt_q;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// entry control state: valid bits, scores, top score
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			top_q   <= tlblru_pkg::SCORE_NONE;
			for (int e = 0; e < TLB_ENTRIES; e++) begin
				score_q[e] <= tlblru_pkg::SCORE_NONE;
			end
		end else if (ctl.fill_commit) begin
			valid_q[vic_q] <= 1'b1;
			score_q[vic_q] <= next_score;
			top_q          <= next_score;
		end else if (ctl.commit) begin
			if (is_xlate) begin
				score_q[hit_idx_q] <= next_score;
				top_q              <= next_score;
			end else if (cmd_q == tlblru_pkg::CMD_FLUSH) begin
				valid_q <= '0;
				top_q   <= tlblru_pkg::SCORE_NONE;
				for (int e = 0; e < TLB_ENTRIES; e++) begin
					score_q[e] <= tlblru_pkg::SCORE_NONE;
				end
			end
		end
	end

	// entry payload on refill
	always_ff @(posedge clk) begin
		if (ctl.fill_commit) begin
			ent_page_q[vic_q]  <= page_q;
			ent_frame_q[vic_q] <= pt_rd_q;
		end
	end

	// page-table memory, registered read
	always_ff @(posedge clk) begin
		if (ctl.commit && cmd_q == tlblru_pkg::CMD_PT_WRITE) begin
			pt_mem[pt_addr] <= tword_q;
		end
		if (ctl.miss_start) begin
			pt_rd_q <= pt_mem[pt_addr];
		end
	end

	// result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.commit || ctl.fill_commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (ctl.fill_commit) begin
			phys_q <= pt_rd_q + tlblru_pkg::PA_W'(off_q);
			ohit_q <= 1'b0;
			slot_q <= tlblru_pkg::SLOT_W'(vic_q);
		end else if (ctl.commit) begin
			if (is_xlate) begin
				phys_q <= ent_frame_q[hit_idx_q] + tlblru_pkg::PA_W'(off_q);
				ohit_q <= 1'b1;
				slot_q <= tlblru_pkg::SLOT_W'(hit_idx_q);
			end else begin
				phys_q <= '0;
				ohit_q <= 1'b0;
				slot_q <= '0;
			end
		end
	end

	// table base register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_base_q <= '0;
		end else if (cfg_we) begin
			table_base_q <= cfg_wdata;
		end
	end

	assign table_base = table_base_q;
	assign out_valid  = out_valid_q;
	assign out_phys   = phys_q;
	assign out_hit    = ohit_q;
	assign out_slot   = slot_q;

	assign stat.xlate      = is_xlate;
	assign stat.hit        = hit_q;
	assign stat.free_avail = free_q;
	assign stat.scan_last  = (cnt_q == LAST_IDX);
	assign stat.out_free   = out_free;

	// a page is never held by two valid entries
	a_unique_page: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.capture |-> $onehot0(match))
		else $error("page present in more than one entry");

	// a result never overwrites a beat still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.commit || ctl.fill_commit) |-> out_free)
		else $error("result written over a pending beat");

	// the refilled entry becomes valid and holds the top score
	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fill_commit |=> valid_q[$past(vic_q)] && score_q[$past(vic_q)] == top_q)
		else $error("refilled entry not valid at top score");

	// a flush empties the buffer and restarts the scores
	a_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.commit && cmd_q == tlblru_pkg::CMD_FLUSH) |=>
			(valid_q == '0 && top_q == tlblru_pkg::SCORE_NONE))
		else $error("flush left entries behind");

endmodule

### hdl/tlblru_ctrl.sv
// ----------------------------------------------------------------------------
// tlblru_ctrl: translation buffer sequencer
// Steps one item through capture, execute, victim scan and refill.
// ----------------------------------------------------------------------------
module tlblru_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tlblru_pkg::dp_stat_t  stat,
	output tlblru_pkg::dp_cmd_t   ctl
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_FILL
	} state_t;

	state_t state_q;
	logic   ready_q;

	// command decode
	always_comb begin
		ctl = '0;
		case (state_q)
			S_IDLE: begin
				ctl.capture = in_valid && ready_q;
			end
			S_EXEC: begin
				if (stat.xlate && !stat.hit) begin
					ctl.miss_start = 1'b1;
				end else begin
					ctl.commit = stat.out_free;
				end
			end
			S_SCAN: begin
				ctl.scan_step = 1'b1;
			end
			S_FILL: begin
				ctl.fill_commit = stat.out_free;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	// state and registered ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (ctl.capture) begin
						state_q <= S_EXEC;
						ready_q <= 1'b0;
					end
				end
				S_EXEC: begin
					if (ctl.miss_start) begin
						state_q <= stat.free_avail ? S_FILL : S_SCAN;
					end else if (ctl.commit) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				S_SCAN: begin
					if (stat.scan_last) begin
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					if (ctl.fill_commit) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready = ready_q;

endmodule

### hdl/tlb_lru_translate.sv
// ----------------------------------------------------------------------------
// tlb_lru_translate: fully associative TLB with score-based LRU refill
// Translates 24-bit virtual addresses through TLB_ENTRIES entries, refilling
// from a page-table memory of TABLE_ENTRIES words on a miss.
// ----------------------------------------------------------------------------
// One item is in flight at a time and every item yields one result beat.
// A translate hit, a page-table write, a flush and the unused command each
// go through the execute state to a registered result. A miss while an entry
// is empty adds the page-table read and the refill state. A miss with the
// buffer full also passes the scan state, where the victim is found by
// comparing one entry score per cycle. A result that is not taken holds the
// sequencer; the next item is accepted as soon as the result is registered.
// The page table has no reset or clearing pass: read only what was written.
// table_base lives at byte address 0 of the register port.
// ----------------------------------------------------------------------------
module tlb_lru_translate #(
	parameter int TLB_ENTRIES   = 8,
	parameter int TABLE_ENTRIES = 16384
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	tlblru_req_if.sink                             req,
	tlblru_rsp_if.source                           rsp,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [tlblru_pkg::PADDR_W-1:0]         paddr,
	input  logic [tlblru_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [tlblru_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                   pready
);

	tlblru_pkg::dp_cmd_t               ctl;
	tlblru_pkg::dp_stat_t              stat;
	logic                              cfg_we;
	logic                              reg_sel;
	logic [tlblru_pkg::TIDX_W-1:0]     table_base;

	// register decode
	assign reg_sel = (paddr[tlblru_pkg::PADDR_W-1:2] == tlblru_pkg::REG_TABLE_BASE);
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready && reg_sel;
	assign prdata  = reg_sel ? tlblru_pkg::APB_DATA_W'(table_base) : '0;

	tlblru_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	tlblru_dp #(
		.TLB_ENTRIES   (TLB_ENTRIES),
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.in_cmd     (req.cmd),
		.in_va      (req.virt_addr),
		.in_tidx    (req.table_index),
		.in_tword   (req.table_word),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.out_phys   (rsp.phys_addr),
		.out_hit    (rsp.hit),
		.out_slot   (rsp.slot),
		.cfg_we     (cfg_we),
		.cfg_wdata  (pwdata[tlblru_pkg::TIDX_W-1:0]),
		.table_base (table_base)
	);

endmodule

### dv/tlb_lru_translate_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_lru_translate_tb: self-checking bench for the LRU translation buffer
// Sends translate, page-table write, flush and unused-command beats, predicts
// every result beat from a shadow copy of the buffer, its scores and the page
// table, and checks response beats in order. table_base is moved between
// phases through the register port and read back.
// ----------------------------------------------------------------------------
module tlb_lru_translate_tb;

	localparam int TLB_N      = 8;
	localparam int PT_N       = 16384;
	localparam int SCORE_CEIL = 32'h0FFF_FFFF;
	localparam int POOL_N     = 12;
	localparam logic [tlblru_pkg::CMD_W-1:0]   CMD_NOP         = 2'd3;
	localparam logic [tlblru_pkg::PADDR_W-1:0] ADDR_TABLE_BASE =
		{tlblru_pkg::REG_TABLE_BASE, 2'b00};

	typedef struct packed {
		logic [tlblru_pkg::PA_W-1:0]   phys_addr;
		logic                          hit;
		logic [tlblru_pkg::SLOT_W-1:0] slot;
	} xlat_rsp_t;

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              psel;
	logic                              penable;
	logic                              pwrite;
	logic [tlblru_pkg::PADDR_W-1:0]    paddr;
	logic [tlblru_pkg::APB_DATA_W-1:0] pwdata;
	logic [tlblru_pkg::APB_DATA_W-1:0] prdata;
	logic                              pready;

	tlblru_req_if req_bus();
	tlblru_rsp_if rsp_bus();

	tlb_lru_translate #(
		.TLB_ENTRIES  (TLB_N),
		.TABLE_ENTRIES(PT_N)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// shadow state of the buffer and its page table
	logic [tlblru_pkg::TIDX_W-1:0]  cur_table_base;
	logic                           tlb_valid [TLB_N];
	logic [tlblru_pkg::PAGE_W-1:0]  tlb_page  [TLB_N];
	logic [tlblru_pkg::PA_W-1:0]    tlb_frame [TLB_N];
	int                             tlb_score [TLB_N];
	logic [tlblru_pkg::TWORD_W-1:0] pt_word   [PT_N];
	bit                             pt_written[PT_N];

	xlat_rsp_t                     pending_xlat_q[$];
	int                            err_cnt   = 0;
	bit                            tx_nogap  = 1'b0;
	bit                            rx_nogap  = 1'b0;
	int                            rx_hold   = 0;
	logic [tlblru_pkg::PAGE_W-1:0] page_pool[POOL_N];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------------
	function automatic void clear_tlb();
		for (int e = 0; e < TLB_N; e++) begin
			tlb_valid[e] = 1'b0;
			tlb_page[e]  = '0;
			tlb_frame[e] = '0;
			tlb_score[e] = -1;
		end
	endfunction

	// highest score plus one, saturating at the ceiling
	function automatic int bumped_score();
		int top;
		top = -1;
		for (int e = 0; e < TLB_N; e++)
			if (tlb_score[e] > top)
				top = tlb_score[e];
		return (top >= SCORE_CEIL) ? SCORE_CEIL : top + 1;
	endfunction

	function automatic int find_entry(logic [tlblru_pkg::PAGE_W-1:0] page);
		for (int e = 0; e < TLB_N; e++)
			if (tlb_valid[e] && tlb_page[e] == page)
				return e;
		return -1;
	endfunction

	function automatic logic [tlblru_pkg::TIDX_W-1:0] table_slot(
		logic [tlblru_pkg::PAGE_W-1:0] page);
		return tlblru_pkg::TIDX_W'((int'(cur_table_base) + int'(page)) % PT_N);
	endfunction

	// result of one accepted beat; updates the shadow state
	function automatic xlat_rsp_t predict_translation(logic [tlblru_pkg::CMD_W-1:0] cmd,
		logic [tlblru_pkg::VA_W-1:0] va, logic [tlblru_pkg::TIDX_W-1:0] tidx,
		logic [tlblru_pkg::TWORD_W-1:0] tword);
		xlat_rsp_t                     r;
		int                            e;
		logic [tlblru_pkg::PAGE_W-1:0] page;
		r    = '0;
		page = va[tlblru_pkg::VA_W-1:tlblru_pkg::OFF_W];
		case (cmd)
			tlblru_pkg::CMD_XLATE: begin
				e = find_entry(page);
				if (e >= 0) begin
					tlb_score[e] = bumped_score();
					r.hit        = 1'b1;
				end else begin
					// victim: first entry with the lowest score, empties at -1
					e = 0;
					for (int i = 1; i < TLB_N; i++)
						if (tlb_score[i] < tlb_score[e])
							e = i;
					tlb_score[e] = bumped_score();
					tlb_valid[e] = 1'b1;
					tlb_page[e]  = page;
					tlb_frame[e] = pt_word[table_slot(page)];
				end
				r.phys_addr = tlb_frame[e] +
					tlblru_pkg::PA_W'(va[tlblru_pkg::OFF_W-1:0]);
				r.slot      = tlblru_pkg::SLOT_W'(e);
			end
			tlblru_pkg::CMD_PT_WRITE: begin
				pt_word[tidx]    = tword;
				pt_written[tidx] = 1'b1;
			end
			tlblru_pkg::CMD_FLUSH: clear_tlb();
			default: ; // unused command: no effect, all-zero result
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------------
	task automatic send_item(logic [tlblru_pkg::CMD_W-1:0] cmd,
		logic [tlblru_pkg::VA_W-1:0] va, logic [tlblru_pkg::TIDX_W-1:0] tidx,
		logic [tlblru_pkg::TWORD_W-1:0] tword);
		int gap;
		gap = tx_nogap ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid       <= 1'b1;
		req_bus.cmd         <= cmd;
		req_bus.virt_addr   <= va;
		req_bus.table_index <= tidx;
		req_bus.table_word  <= tword;
		do @(posedge clk); while (!req_bus.ready);
		pending_xlat_q.push_back(predict_translation(cmd, va, tidx, tword));
	endtask

	// translate; a miss on a never-written table word gets that word first
	task automatic xlate(logic [tlblru_pkg::VA_W-1:0] va);
		logic [tlblru_pkg::TIDX_W-1:0] where;
		where = table_slot(va[tlblru_pkg::VA_W-1:tlblru_pkg::OFF_W]);
		if (find_entry(va[tlblru_pkg::VA_W-1:tlblru_pkg::OFF_W]) < 0 && !pt_written[where])
			send_item(tlblru_pkg::CMD_PT_WRITE, tlblru_pkg::VA_W'($urandom), where,
				tlblru_pkg::TWORD_W'($urandom));
		send_item(tlblru_pkg::CMD_XLATE, va, tlblru_pkg::TIDX_W'($urandom),
			tlblru_pkg::TWORD_W'($urandom));
	endtask

	task automatic pt_write(logic [tlblru_pkg::TIDX_W-1:0] tidx,
		logic [tlblru_pkg::TWORD_W-1:0] tword);
		send_item(tlblru_pkg::CMD_PT_WRITE, tlblru_pkg::VA_W'($urandom), tidx, tword);
	endtask

	// drop valid and wait until every result beat is back
	task automatic wait_drain();
		req_bus.valid <= 1'b0;
		while (pending_xlat_q.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// register port
	// ------------------------------------------------------------------------
	task automatic apb_access(logic wr, logic [tlblru_pkg::PADDR_W-1:0] addr,
		logic [tlblru_pkg::APB_DATA_W-1:0] wdata,
		output logic [tlblru_pkg::APB_DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_table_base();
		logic [tlblru_pkg::APB_DATA_W-1:0] rd;
		apb_access(1'b0, ADDR_TABLE_BASE, '0, rd);
		if (rd[tlblru_pkg::TIDX_W-1:0] !== cur_table_base) begin
			$error("table_base readback: expected %0d, got %0d", cur_table_base,
				rd[tlblru_pkg::TIDX_W-1:0]);
			err_cnt++;
		end
	endtask

	task automatic set_table_base(logic [tlblru_pkg::TIDX_W-1:0] b);
		logic [tlblru_pkg::APB_DATA_W-1:0] rd;
		wait_drain();
		apb_access(1'b1, ADDR_TABLE_BASE, tlblru_pkg::APB_DATA_W'(b), rd);
		cur_table_base = b;
		check_table_base();
	endtask

	// ------------------------------------------------------------------------
	// response side: random stalls, plus a long hold-off on request
	// ------------------------------------------------------------------------
	initial begin : rsp_stall
		int n;
		rsp_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold > 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end
			n = rx_nogap ? 0 : $urandom_range(0, 19);
			if (n > 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			rsp_bus.ready <= 1'b1;
			do @(posedge clk); while (!rsp_bus.valid);
		end
	end

	// each result beat against the oldest prediction
	always @(posedge clk) begin : rsp_check
		xlat_rsp_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (pending_xlat_q.size() == 0) begin
				$error("result beat with nothing pending: phys_addr %06h hit %0b slot %0d",
					rsp_bus.phys_addr, rsp_bus.hit, rsp_bus.slot);
				err_cnt++;
			end else begin
				want = pending_xlat_q.pop_front();
				if (rsp_bus.phys_addr !== want.phys_addr) begin
					$error("phys_addr: expected %06h, got %06h", want.phys_addr,
						rsp_bus.phys_addr);
					err_cnt++;
				end
				if (rsp_bus.hit !== want.hit) begin
					$error("hit: expected %0b, got %0b", want.hit, rsp_bus.hit);
					err_cnt++;
				end
				if (rsp_bus.slot !== want.slot) begin
					$error("slot: expected %0d, got %0d", want.slot, rsp_bus.slot);
					err_cnt++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_table_base_reg();
		check_table_base();
		set_table_base(tlblru_pkg::TIDX_W'(PT_N - 1));
		set_table_base('0);
	endtask

	// fill empties, hit, wrap the physical address, then evict from a full buffer
	task automatic test_directed_translate();
		pt_write(0, 24'hFF_FFFF);
		pt_write(1, 24'h00_0000);
		for (int p = 2; p <= TLB_N; p++)
			pt_write(tlblru_pkg::TIDX_W'(p), tlblru_pkg::TWORD_W'($urandom));
		xlate(24'h0000_FF);
		xlate(24'h0000_00);
		for (int p = 1; p < TLB_N; p++)
			xlate({tlblru_pkg::PAGE_W'(p), tlblru_pkg::OFF_W'($urandom)});
		xlate({tlblru_pkg::PAGE_W'(TLB_N), 8'hFF});
		xlate(24'h0000_01);
		wait_drain();
	endtask

	task automatic test_flush_and_nop();
		send_item(CMD_NOP, 24'hFF_FFFF, '1, 24'hFF_FFFF);
		send_item(tlblru_pkg::CMD_FLUSH, tlblru_pkg::VA_W'($urandom),
			tlblru_pkg::TIDX_W'($urandom), tlblru_pkg::TWORD_W'($urandom));
		xlate(24'h0001_80);
		wait_drain();
	endtask

	// table_base plus page past the end of the table wraps around
	task automatic test_table_wrap();
		set_table_base(tlblru_pkg::TIDX_W'(PT_N - 1));
		pt_write(tlblru_pkg::TIDX_W'(PT_N - 1), tlblru_pkg::TWORD_W'($urandom));
		xlate(24'h0000_3C);
		xlate(24'hFFFF_FF);
		set_table_base('0);
	endtask

	// receiver holds off while the sender keeps offering beats
	task automatic test_output_backpressure();
		tx_nogap = 1'b1;
		rx_hold  = 150;
		for (int i = 0; i < 12; i++)
			xlate({tlblru_pkg::PAGE_W'($urandom_range(0, 5)),
				tlblru_pkg::OFF_W'($urandom)});
		wait_drain();
		tx_nogap = 1'b0;
	endtask

	task automatic test_random_traffic();
		logic [tlblru_pkg::TIDX_W-1:0] bases[4];
		int                            r;
		bases = '{'0, tlblru_pkg::TIDX_W'(PT_N - 1), tlblru_pkg::TIDX_W'($urandom),
			tlblru_pkg::TIDX_W'($urandom)};
		for (int ph = 0; ph < 4; ph++) begin
			set_table_base(bases[ph]);
			// working set a bit larger than the buffer, so evictions keep happening
			for (int i = 0; i < POOL_N; i++)
				page_pool[i] = tlblru_pkg::PAGE_W'($urandom);
			tx_nogap = (ph == 2);
			rx_nogap = (ph == 2);
			for (int n = 0; n < 165; n++) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					xlate({page_pool[$urandom_range(0, POOL_N - 1)],
						tlblru_pkg::OFF_W'($urandom)});
				else if (r < 80)
					xlate(tlblru_pkg::VA_W'($urandom));
				else if (r < 90)
					pt_write(tlblru_pkg::TIDX_W'($urandom), tlblru_pkg::TWORD_W'($urandom));
				else if (r < 95)
					send_item(tlblru_pkg::CMD_FLUSH, tlblru_pkg::VA_W'($urandom),
						tlblru_pkg::TIDX_W'($urandom), tlblru_pkg::TWORD_W'($urandom));
				else
					send_item(CMD_NOP, tlblru_pkg::VA_W'($urandom),
						tlblru_pkg::TIDX_W'($urandom), tlblru_pkg::TWORD_W'($urandom));
			end
			wait_drain();
		end
		tx_nogap = 1'b0;
		rx_nogap = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n              <= 1'b0;
		psel                <= 1'b0;
		penable             <= 1'b0;
		pwrite              <= 1'b0;
		paddr               <= '0;
		pwdata              <= '0;
		req_bus.valid       <= 1'b0;
		req_bus.cmd         <= tlblru_pkg::CMD_XLATE;
		req_bus.virt_addr   <= '0;
		req_bus.table_index <= '0;
		req_bus.table_word  <= '0;
		cur_table_base = '0;
		clear_tlb();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_table_base_reg();
		test_directed_translate();
		test_flush_and_nop();
		test_table_wrap();
		test_output_backpressure();
		test_random_traffic();

		wait_drain();
		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog
	initial begin
		#1_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

### files.f
hdl/tlblru_pkg.sv
hdl/tlblru_ifs.sv
hdl/tlblru_dp.sv
hdl/tlblru_ctrl.sv
hdl/tlb_lru_translate.sv
dv/tlb_lru_translate_tb.sv
